// ----- src/triangle_plane_clipper_assert.svh -----
// Assertion macros used by the triangle plane clipper checker.
// Needs nothing else; files that assert include it by name.
`ifndef TRIANGLE_PLANE_CLIPPER_ASSERT_SVH
`define TRIANGLE_PLANE_CLIPPER_ASSERT_SVH

// The consequence must hold in the cycle after the antecedent.
`define TPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The consequence must hold in the same cycle as the antecedent.
`define TPC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- src/tpc_pkg.sv -----
// Types, constants and helper functions of the triangle plane clipper.
// Standalone; every other source file of the block but the assertion header refers to it by scope.
`timescale 1ns / 1ps

package tpc_pkg;

   localparam int COORD_W        = 32;
   localparam int NORM_W         = 18;
   localparam int OFF_W          = 32;
   localparam int COLOR_W        = 32;
   localparam int LIGHT_W        = 16;
   localparam int DATA_W         = 32;
   localparam int ADDR_W         = 4;
   localparam int OFFSET_SHIFT   = 16;
   localparam int PROD_W         = 50;
   localparam int DIST_W         = 51;
   localparam int DEN_W          = 51;
   localparam int FRAC_W         = 32;
   localparam int FRAC_HALF      = FRAC_W / 2;
   localparam int DIV_STEP_BITS  = 2;
   localparam int DIV_STAGES     = FRAC_W / DIV_STEP_BITS;
   localparam int CROSS_LAT      = DIV_STAGES + 3;
   localparam int PART_W         = COORD_W + FRAC_HALF;
   localparam int SUM_W          = COORD_W + FRAC_W;
   localparam int STEP_W         = COORD_W + 2;

   localparam logic [1:0] REG_NORMAL_X = 2'd0;
   localparam logic [1:0] REG_NORMAL_Y = 2'd1;
   localparam logic [1:0] REG_NORMAL_Z = 2'd2;
   localparam logic [1:0] REG_OFFSET   = 2'd3;

   typedef enum logic [1:0] {VTX_A, VTX_B, VTX_C} vtx_sel_type;

   typedef enum logic [1:0] {
      CLIP_NONE,
      CLIP_ONE_IN,
      CLIP_TWO_IN,
      CLIP_ALL_IN
   } clip_kind_type;

   // Index 0 is x, 1 is y, 2 is z.
   typedef logic [2:0][COORD_W-1:0] vertex_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] a_z;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] b_z;
      logic signed [COORD_W-1:0] c_x;
      logic signed [COORD_W-1:0] c_y;
      logic signed [COORD_W-1:0] c_z;
      logic [COLOR_W-1:0]        tri_color;
      logic signed [LIGHT_W-1:0] tri_light;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_a_x;
      logic signed [COORD_W-1:0] out_a_y;
      logic signed [COORD_W-1:0] out_a_z;
      logic signed [COORD_W-1:0] out_b_x;
      logic signed [COORD_W-1:0] out_b_y;
      logic signed [COORD_W-1:0] out_b_z;
      logic signed [COORD_W-1:0] out_c_x;
      logic signed [COORD_W-1:0] out_c_y;
      logic signed [COORD_W-1:0] out_c_z;
      logic [COLOR_W-1:0]        out_color;
      logic signed [LIGHT_W-1:0] out_light;
      logic                      last_piece;
   } rsp_payload_type;

   typedef struct packed {
      clip_kind_type             kind;
      vertex_type                k0;
      vertex_type                k1;
      vertex_type                k2;
      logic [COLOR_W-1:0]        color;
      logic signed [LIGHT_W-1:0] light;
   } side_type;

   typedef struct packed {
      vertex_type       s;
      vertex_type       e;
      logic [DEN_W-1:0] ds;
      logic [DEN_W-1:0] den;
   } cross_in_type;

   typedef struct packed {
      side_type   side;
      vertex_type x0;
      vertex_type x1;
   } entry_type;

   typedef struct packed {
      logic [DEN_W-1:0]  rem;
      logic [FRAC_W-1:0] quo;
   } div_state_type;

   // Restoring division, a few quotient bits per call.
   function automatic div_state_type div_steps(div_state_type st, logic [DEN_W-1:0] den);
      div_state_type r;
      logic [DEN_W:0] r2;
      r = st;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         r2 = {r.rem, 1'b0};
         if (r2 >= {1'b0, den}) begin
            r.rem = DEN_W'(r2 - {1'b0, den});
            r.quo = {r.quo[FRAC_W-2:0], 1'b1};
         end else begin
            r.rem = DEN_W'(r2);
            r.quo = {r.quo[FRAC_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic vertex_type vertex_of(req_payload_type p, vtx_sel_type sel);
      vertex_type v;
      case (sel)
         VTX_A: begin
            v[0] = p.a_x; v[1] = p.a_y; v[2] = p.a_z;
         end
         VTX_B: begin
            v[0] = p.b_x; v[1] = p.b_y; v[2] = p.b_z;
         end
         default: begin
            v[0] = p.c_x; v[1] = p.c_y; v[2] = p.c_z;
         end
      endcase
      return v;
   endfunction

   function automatic logic signed [DIST_W-1:0] dist_of(vtx_sel_type sel,
                                                       logic signed [DIST_W-1:0] da,
                                                       logic signed [DIST_W-1:0] db,
                                                       logic signed [DIST_W-1:0] dc);
      logic signed [DIST_W-1:0] d;
      case (sel)
         VTX_A:   d = da;
         VTX_B:   d = db;
         default: d = dc;
      endcase
      return d;
   endfunction

endpackage

// ----- src/triangle_plane_clipper.sv -----
// Channel   Direction  Carries
// req_      in         one triangle: three Q16.16 vertices, color, light
// rsp_      out        zero, one or two clipped triangles per request
// APB       in/out     plane normal x, y, z and plane offset
//
// A request may be accepted every cycle while queue credit remains; each
// result triangle is a separate output transfer, so a request cut into a quad
// uses two. A request passes the registered distance lanes, the classification
// register and the 16-stage divider in each intersection lane before the queue.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// A stalled output holds its triangle while the pipeline keeps taking requests
// until the credit count reaches the queue depth.
`timescale 1ns / 1ps

module triangle_plane_clipper #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tpc_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tpc_pkg::rsp_payload_type      rsp_payload,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tpc_pkg::ADDR_W-1:0]    paddr,
   input  logic [tpc_pkg::DATA_W-1:0]    pwdata,
   output logic [tpc_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic signed [tpc_pkg::NORM_W-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [tpc_pkg::OFF_W-1:0]  off_ff;
   logic                              cfg_write;

   logic                       accept;
   logic [CW-1:0]              inflight_ff, inflight_in;
   logic [CW-1:0]              queue_count;

   logic                       s0_valid_ff, s1_valid_ff, s2_valid_ff;
   tpc_pkg::req_payload_type   s0_item_ff, s1_item_ff, s2_item_ff;
   logic signed [tpc_pkg::DIST_W-1:0] vtx_dist [3];

   tpc_pkg::vtx_sel_type       g0, g1, o0, s1_sel, e1_sel;
   tpc_pkg::vtx_sel_type       o1;
   logic [2:0]                 in_mask;
   logic signed [tpc_pkg::DIST_W-1:0] ds0, de0, ds1, de1;
   tpc_pkg::side_type          cls_side_in, cls_side_ff;
   tpc_pkg::cross_in_type      cross_in [2], cross_ff [2];
   logic                       cls_valid_ff;

   tpc_pkg::side_type          side_ff  [tpc_pkg::CROSS_LAT];
   logic                       sval_ff  [tpc_pkg::CROSS_LAT];
   tpc_pkg::vertex_type        xpt [2];
   logic                       tail_valid;
   logic                       push;
   tpc_pkg::entry_type         push_entry;

   // Configuration registers.
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff  <= tpc_pkg::NORM_W'(0);
         ny_ff  <= tpc_pkg::NORM_W'(0);
         nz_ff  <= tpc_pkg::NORM_W'(65536);
         off_ff <= tpc_pkg::OFF_W'(6554);
      end else if (cfg_write) begin
         case (paddr[3:2])
            tpc_pkg::REG_NORMAL_X: nx_ff  <= pwdata[tpc_pkg::NORM_W-1:0];
            tpc_pkg::REG_NORMAL_Y: ny_ff  <= pwdata[tpc_pkg::NORM_W-1:0];
            tpc_pkg::REG_NORMAL_Z: nz_ff  <= pwdata[tpc_pkg::NORM_W-1:0];
            tpc_pkg::REG_OFFSET:   off_ff <= pwdata[tpc_pkg::OFF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         tpc_pkg::REG_NORMAL_X: prdata = tpc_pkg::DATA_W'(nx_ff);
         tpc_pkg::REG_NORMAL_Y: prdata = tpc_pkg::DATA_W'(ny_ff);
         tpc_pkg::REG_NORMAL_Z: prdata = tpc_pkg::DATA_W'(nz_ff);
         default:               prdata = tpc_pkg::DATA_W'(off_ff);
      endcase
   end

   // Credit: every request in the pipeline or the queue holds one entry.
   assign req_stall = ((CW+1)'(inflight_ff) + (CW+1)'(queue_count)) >= (CW+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign inflight_in = inflight_ff + CW'(accept) - CW'(tail_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff  <= '0;
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         cls_valid_ff <= 1'b0;
      end else begin
         inflight_ff  <= inflight_in;
         s0_valid_ff  <= accept;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         cls_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_item_ff <= req_payload;
      end
      s1_item_ff  <= s0_item_ff;
      s2_item_ff  <= s1_item_ff;
      cls_side_ff <= cls_side_in;
      cross_ff    <= cross_in;
   end

   for (genvar i = 0; i < 3; i++) begin : g_dist
      tpc_dist_lane u_dist (
         .clock    (clock),
         .vtx      (tpc_pkg::vertex_of(s0_item_ff, tpc_pkg::vtx_sel_type'(i))),
         .normal_x (nx_ff),
         .normal_y (ny_ff),
         .normal_z (nz_ff),
         .offset   (off_ff),
         .distance (vtx_dist[i])
      );
   end

   // Sort the vertices into inside and outside ones, keeping input order.
   always_comb begin
      in_mask = {~vtx_dist[2][tpc_pkg::DIST_W-1], ~vtx_dist[1][tpc_pkg::DIST_W-1],
                 ~vtx_dist[0][tpc_pkg::DIST_W-1]};
      g0 = tpc_pkg::VTX_A;
      g1 = tpc_pkg::VTX_B;
      o0 = tpc_pkg::VTX_B;
      o1 = tpc_pkg::VTX_C;
      cls_side_in.kind = tpc_pkg::CLIP_NONE;
      case (in_mask)
         3'b111: cls_side_in.kind = tpc_pkg::CLIP_ALL_IN;
         3'b001: begin
            cls_side_in.kind = tpc_pkg::CLIP_ONE_IN;
            g0 = tpc_pkg::VTX_A; o0 = tpc_pkg::VTX_B; o1 = tpc_pkg::VTX_C;
         end
         3'b010: begin
            cls_side_in.kind = tpc_pkg::CLIP_ONE_IN;
            g0 = tpc_pkg::VTX_B; o0 = tpc_pkg::VTX_A; o1 = tpc_pkg::VTX_C;
         end
         3'b100: begin
            cls_side_in.kind = tpc_pkg::CLIP_ONE_IN;
            g0 = tpc_pkg::VTX_C; o0 = tpc_pkg::VTX_A; o1 = tpc_pkg::VTX_B;
         end
         3'b011: begin
            cls_side_in.kind = tpc_pkg::CLIP_TWO_IN;
            g0 = tpc_pkg::VTX_A; g1 = tpc_pkg::VTX_B; o0 = tpc_pkg::VTX_C;
         end
         3'b101: begin
            cls_side_in.kind = tpc_pkg::CLIP_TWO_IN;
            g0 = tpc_pkg::VTX_A; g1 = tpc_pkg::VTX_C; o0 = tpc_pkg::VTX_B;
         end
         3'b110: begin
            cls_side_in.kind = tpc_pkg::CLIP_TWO_IN;
            g0 = tpc_pkg::VTX_B; g1 = tpc_pkg::VTX_C; o0 = tpc_pkg::VTX_A;
         end
         default: cls_side_in.kind = tpc_pkg::CLIP_NONE;
      endcase

      // The second lane cuts g0 to o1 for one inside vertex, g1 to o0 for two.
      s1_sel = (cls_side_in.kind == tpc_pkg::CLIP_TWO_IN) ? g1 : g0;
      e1_sel = (cls_side_in.kind == tpc_pkg::CLIP_TWO_IN) ? o0 : o1;

      cls_side_in.k0    = tpc_pkg::vertex_of(s2_item_ff, g0);
      cls_side_in.k1    = tpc_pkg::vertex_of(s2_item_ff, g1);
      cls_side_in.k2    = tpc_pkg::vertex_of(s2_item_ff, tpc_pkg::VTX_C);
      cls_side_in.color = s2_item_ff.tri_color;
      cls_side_in.light = s2_item_ff.tri_light;

      ds0 = tpc_pkg::dist_of(g0, vtx_dist[0], vtx_dist[1], vtx_dist[2]);
      de0 = tpc_pkg::dist_of(o0, vtx_dist[0], vtx_dist[1], vtx_dist[2]);
      ds1 = tpc_pkg::dist_of(s1_sel, vtx_dist[0], vtx_dist[1], vtx_dist[2]);
      de1 = tpc_pkg::dist_of(e1_sel, vtx_dist[0], vtx_dist[1], vtx_dist[2]);

      cross_in[0].s   = cls_side_in.k0;
      cross_in[0].e   = tpc_pkg::vertex_of(s2_item_ff, o0);
      cross_in[0].ds  = tpc_pkg::DEN_W'(ds0);
      cross_in[0].den = tpc_pkg::DEN_W'((tpc_pkg::DIST_W+1)'(ds0)
                                       - (tpc_pkg::DIST_W+1)'(de0));
      cross_in[1].s   = tpc_pkg::vertex_of(s2_item_ff, s1_sel);
      cross_in[1].e   = tpc_pkg::vertex_of(s2_item_ff, e1_sel);
      cross_in[1].ds  = tpc_pkg::DEN_W'(ds1);
      cross_in[1].den = tpc_pkg::DEN_W'((tpc_pkg::DIST_W+1)'(ds1)
                                       - (tpc_pkg::DIST_W+1)'(de1));
   end

   for (genvar i = 0; i < 2; i++) begin : g_cross
      tpc_cross_lane u_cross (
         .clock    (clock),
         .cross_in (cross_ff[i]),
         .point    (xpt[i])
      );
   end

   // Side data travels alongside the intersection lanes.
   for (genvar k = 0; k < tpc_pkg::CROSS_LAT; k++) begin : g_side
      if (k == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) begin
               sval_ff[k] <= 1'b0;
            end else begin
               sval_ff[k] <= cls_valid_ff;
            end
            side_ff[k] <= cls_side_ff;
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (reset) begin
               sval_ff[k] <= 1'b0;
            end else begin
               sval_ff[k] <= sval_ff[k-1];
            end
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign tail_valid      = sval_ff[tpc_pkg::CROSS_LAT-1];
   assign push            = tail_valid &&
                            (side_ff[tpc_pkg::CROSS_LAT-1].kind != tpc_pkg::CLIP_NONE);
   assign push_entry.side = side_ff[tpc_pkg::CROSS_LAT-1];
   assign push_entry.x0   = xpt[0];
   assign push_entry.x1   = xpt[1];

   tpc_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_entry  (push_entry),
      .count       (queue_count),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- src/tpc_dist_lane.sv -----
// One distance lane: signed distance of a vertex to the plane, two stages.
// Depends on tpc_pkg for widths and the vertex type.
`timescale 1ns / 1ps

module tpc_dist_lane (
   input  logic                               clock,
   input  tpc_pkg::vertex_type                vtx,
   input  logic signed [tpc_pkg::NORM_W-1:0]  normal_x,
   input  logic signed [tpc_pkg::NORM_W-1:0]  normal_y,
   input  logic signed [tpc_pkg::NORM_W-1:0]  normal_z,
   input  logic signed [tpc_pkg::OFF_W-1:0]   offset,
   output logic signed [tpc_pkg::DIST_W-1:0]  distance
);

   logic signed [tpc_pkg::PROD_W-1:0] prod_x_ff, prod_x_in;
   logic signed [tpc_pkg::PROD_W-1:0] prod_y_ff, prod_y_in;
   logic signed [tpc_pkg::PROD_W-1:0] prod_z_ff, prod_z_in;
   logic signed [tpc_pkg::PROD_W-1:0] off_ff, off_in;
   logic signed [tpc_pkg::DIST_W-1:0] dist_ff, dist_in;

   always_comb begin
      prod_x_in = tpc_pkg::PROD_W'(normal_x) * tpc_pkg::PROD_W'($signed(vtx[0]));
      prod_y_in = tpc_pkg::PROD_W'(normal_y) * tpc_pkg::PROD_W'($signed(vtx[1]));
      prod_z_in = tpc_pkg::PROD_W'(normal_z) * tpc_pkg::PROD_W'($signed(vtx[2]));
      off_in    = tpc_pkg::PROD_W'(offset) <<< tpc_pkg::OFFSET_SHIFT;
      dist_in   = tpc_pkg::DIST_W'(prod_x_ff) + tpc_pkg::DIST_W'(prod_y_ff)
                + tpc_pkg::DIST_W'(prod_z_ff) - tpc_pkg::DIST_W'(off_ff);
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      prod_z_ff <= prod_z_in;
      off_ff    <= off_in;
      dist_ff   <= dist_in;
   end

   assign distance = dist_ff;

endmodule

// ----- src/tpc_cross_lane.sv -----
// One intersection lane: divider pipeline for the edge fraction, then the
// split multiply, rounding and saturation. Depends on tpc_pkg.
`timescale 1ns / 1ps

module tpc_cross_lane (
   input  logic                  clock,
   input  tpc_pkg::cross_in_type cross_in,
   output tpc_pkg::vertex_type   point
);

   localparam int LAST = tpc_pkg::DIV_STAGES - 1;

   tpc_pkg::div_state_type          div_ff  [tpc_pkg::DIV_STAGES];
   logic [tpc_pkg::DEN_W-1:0]       den_ff  [tpc_pkg::DIV_STAGES];
   tpc_pkg::vertex_type             base_ff [tpc_pkg::DIV_STAGES];
   tpc_pkg::vertex_type             mag_ff  [tpc_pkg::DIV_STAGES];
   logic [2:0]                      neg_ff  [tpc_pkg::DIV_STAGES];

   tpc_pkg::div_state_type          div_start;
   logic signed [tpc_pkg::COORD_W:0] delta [3];
   tpc_pkg::vertex_type             mag_in;
   logic [2:0]                      neg_in;

   logic [tpc_pkg::PART_W-1:0]      hi_ff [3], hi_in [3];
   logic [tpc_pkg::PART_W-1:0]      lo_ff [3], lo_in [3];
   tpc_pkg::vertex_type             base_m1_ff;
   logic [2:0]                      neg_m1_ff;

   logic [tpc_pkg::SUM_W-1:0]       sum [3];
   logic [tpc_pkg::COORD_W-1:0]     quo [3];
   logic signed [tpc_pkg::STEP_W-1:0] step [3];
   logic signed [tpc_pkg::STEP_W-1:0] res_ff [3], res_in [3];
   tpc_pkg::vertex_type             point_ff, point_in;

   // Magnitude and sign of the edge vector, taken once at the lane entry.
   always_comb begin
      div_start.rem = cross_in.ds;
      div_start.quo = '0;
      for (int j = 0; j < 3; j++) begin
         delta[j]  = (tpc_pkg::COORD_W+1)'($signed(cross_in.e[j]))
                   - (tpc_pkg::COORD_W+1)'($signed(cross_in.s[j]));
         neg_in[j] = delta[j][tpc_pkg::COORD_W];
         mag_in[j] = neg_in[j] ? tpc_pkg::COORD_W'(-delta[j])
                               : tpc_pkg::COORD_W'(delta[j]);
      end
   end

   for (genvar k = 0; k < tpc_pkg::DIV_STAGES; k++) begin : g_div
      if (k == 0) begin : g_head
         always_ff @(posedge clock) begin
            div_ff[k]  <= tpc_pkg::div_steps(div_start, cross_in.den);
            den_ff[k]  <= cross_in.den;
            base_ff[k] <= cross_in.s;
            mag_ff[k]  <= mag_in;
            neg_ff[k]  <= neg_in;
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            div_ff[k]  <= tpc_pkg::div_steps(div_ff[k-1], den_ff[k-1]);
            den_ff[k]  <= den_ff[k-1];
            base_ff[k] <= base_ff[k-1];
            mag_ff[k]  <= mag_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
         end
      end
   end

   // The 32 by 32 product is formed from two halves of the fraction.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         hi_in[j] = tpc_pkg::PART_W'(mag_ff[LAST][j])
                  * tpc_pkg::PART_W'(div_ff[LAST].quo[tpc_pkg::FRAC_W-1:tpc_pkg::FRAC_HALF]);
         lo_in[j] = tpc_pkg::PART_W'(mag_ff[LAST][j])
                  * tpc_pkg::PART_W'(div_ff[LAST].quo[tpc_pkg::FRAC_HALF-1:0]);
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sum[j] = {hi_ff[j], tpc_pkg::FRAC_HALF'(0)} + tpc_pkg::SUM_W'(lo_ff[j])
                + (tpc_pkg::SUM_W'(1) << (tpc_pkg::FRAC_W - 1));
         quo[j] = sum[j][tpc_pkg::SUM_W-1:tpc_pkg::FRAC_W];
         step[j] = neg_m1_ff[j] ? -$signed(tpc_pkg::STEP_W'(quo[j]))
                                : $signed(tpc_pkg::STEP_W'(quo[j]));
         res_in[j] = tpc_pkg::STEP_W'($signed(base_m1_ff[j])) + step[j];
      end
   end

   // Saturate to the signed 32-bit range.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         if (res_ff[j][tpc_pkg::STEP_W-1:tpc_pkg::COORD_W-1] == '0 ||
             res_ff[j][tpc_pkg::STEP_W-1:tpc_pkg::COORD_W-1] == '1) begin
            point_in[j] = res_ff[j][tpc_pkg::COORD_W-1:0];
         end else if (res_ff[j][tpc_pkg::STEP_W-1]) begin
            point_in[j] = {1'b1, {(tpc_pkg::COORD_W-1){1'b0}}};
         end else begin
            point_in[j] = {1'b0, {(tpc_pkg::COORD_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      base_m1_ff <= base_ff[LAST];
      neg_m1_ff  <= neg_ff[LAST];
      res_ff     <= res_in;
      point_ff   <= point_in;
   end

   assign point = point_ff;

endmodule

// ----- src/tpc_out_queue.sv -----
// Result queue and emitter: holds clipped items and sends their one or two
// triangles through a registered output. Depends on tpc_pkg.
`timescale 1ns / 1ps

module tpc_out_queue #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tpc_pkg::entry_type       push_entry,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tpc_pkg::rsp_payload_type rsp_payload
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   tpc_pkg::entry_type       mem [DEPTH];
   logic [AW-1:0]            wr_ff, wr_in;
   logic [AW-1:0]            rd_ff, rd_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     phase_ff, phase_in;
   logic                     valid_ff, valid_in;
   tpc_pkg::rsp_payload_type out_ff, out_in;
   tpc_pkg::entry_type       head;
   logic                     load;
   logic                     pop;
   logic                     split_first;

   function automatic tpc_pkg::rsp_payload_type build_piece(tpc_pkg::entry_type e,
                                                            logic second);
      tpc_pkg::rsp_payload_type r;
      tpc_pkg::vertex_type v0, v1, v2;
      logic last;
      case (e.side.kind)
         tpc_pkg::CLIP_ONE_IN: begin
            v0 = e.side.k0; v1 = e.x0; v2 = e.x1; last = 1'b1;
         end
         tpc_pkg::CLIP_TWO_IN: begin
            if (second) begin
               v0 = e.side.k1; v1 = e.x0; v2 = e.x1; last = 1'b1;
            end else begin
               v0 = e.side.k0; v1 = e.side.k1; v2 = e.x0; last = 1'b0;
            end
         end
         default: begin
            v0 = e.side.k0; v1 = e.side.k1; v2 = e.side.k2; last = 1'b1;
         end
      endcase
      r.out_a_x    = v0[0];
      r.out_a_y    = v0[1];
      r.out_a_z    = v0[2];
      r.out_b_x    = v1[0];
      r.out_b_y    = v1[1];
      r.out_b_z    = v1[2];
      r.out_c_x    = v2[0];
      r.out_c_y    = v2[1];
      r.out_c_z    = v2[2];
      r.out_color  = e.side.color;
      r.out_light  = e.side.light;
      r.last_piece = last;
      return r;
   endfunction

   always_comb begin
      head        = mem[rd_ff];
      load        = (cnt_ff != '0) && (!valid_ff || !rsp_stall);
      split_first = (head.side.kind == tpc_pkg::CLIP_TWO_IN) && !phase_ff;
      pop         = load && !split_first;

      phase_in = phase_ff;
      out_in   = out_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         phase_in = split_first;
         out_in   = build_piece(head, phase_ff);
         valid_in = 1'b1;
      end

      wr_in = wr_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      rd_in = rd_ff;
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_entry;
      end
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   assign count       = cnt_ff;
   assign rsp_valid   = valid_ff;
   assign rsp_payload = out_ff;

endmodule

// ----- src/tpc_checker.sv -----
// Port-level checks of the triangle plane clipper, bound to its top level.
// Depends on tpc_pkg and triangle_plane_clipper_assert.svh.
`timescale 1ns / 1ps
`include "triangle_plane_clipper_assert.svh"

module tpc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input tpc_pkg::rsp_payload_type      rsp_payload,
   input logic                          psel,
   input logic                          pready
);

   `TPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed or dropped")

   `TPC_ASSERT_NOW(a_pready_high, clock, reset, psel, pready, "configuration access saw wait state")

   // The first half of a quad is always followed at once by its second half.
   `TPC_ASSERT_NEXT(a_quad_follows, clock, reset, rsp_valid && !rsp_stall && !rsp_payload.last_piece, rsp_valid && rsp_payload.last_piece, "second quad triangle missing")

   `TPC_ASSERT_NEXT(a_quad_attr, clock, reset, rsp_valid && !rsp_stall && !rsp_payload.last_piece, rsp_payload.out_color == $past(rsp_payload.out_color) && rsp_payload.out_light == $past(rsp_payload.out_light), "quad halves differ in color or light")

   `TPC_ASSERT_NEXT(a_quad_shared, clock, reset, rsp_valid && !rsp_stall && !rsp_payload.last_piece, rsp_payload.out_a_x == $past(rsp_payload.out_b_x) && rsp_payload.out_a_y == $past(rsp_payload.out_b_y) && rsp_payload.out_a_z == $past(rsp_payload.out_b_z), "quad halves do not share the second inside vertex")

endmodule

bind triangle_plane_clipper tpc_checker u_tpc_checker (.*);
